### rtl/core/segi_pkg.sv
// Shared types and constants for the segment intersection unit.
// No dependencies; every other file refers to it by scoped names.
package segi_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int TOL_BITS       = 20;
  localparam int OUT_BITS       = 32;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_POINT   = 2'd1,
    KIND_SEGMENT = 2'd2
  } kind_t;

endpackage

### rtl/core/segi_orient.sv
// Orientation front end: coordinate differences, products, cross products.
// Three register stages. Depends on segi_pkg.
module segi_orient #(
  parameter int COORD_BITS = segi_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [COORD_BITS-1:0]      in_pt [8],
  output logic                              out_valid,
  output logic signed [COORD_BITS-1:0]      out_pt [8],
  output logic signed [2*COORD_BITS+1:0]    out_cross [5],
  output logic signed [COORD_BITS:0]        out_rx,
  output logic signed [COORD_BITS:0]        out_ry
);

  localparam int DW = COORD_BITS + 1;
  localparam int XW = 2 * COORD_BITS + 2;

  // differences: ab, ac, ad, cd, ca, cb (x then y)
  localparam int DIF_P [12] = '{2, 3, 4, 5, 6, 7, 6, 7, 0, 1, 2, 3};
  localparam int DIF_Q [12] = '{0, 1, 0, 1, 0, 1, 4, 5, 4, 5, 4, 5};
  // product pairs; cross j = prod 2j - prod 2j+1 (c, d vs ab; a, b vs cd; den)
  localparam int PROD_A [10] = '{0, 1, 0, 1, 6, 7, 6, 7, 0, 1};
  localparam int PROD_B [10] = '{3, 2, 5, 4, 9, 8, 11, 10, 7, 6};

  logic                   v1_r, v2_r, v3_r;
  logic signed [COORD_BITS-1:0] pt1_r [8];
  logic signed [COORD_BITS-1:0] pt2_r [8];
  logic signed [COORD_BITS-1:0] pt3_r [8];
  logic signed [DW-1:0]   dif_nxt [12];
  logic signed [DW-1:0]   dif_r [12];
  logic signed [XW-1:0]   prod_nxt [10];
  logic signed [XW-1:0]   prod_r [10];
  logic signed [XW-1:0]   cross_nxt [5];
  logic signed [XW-1:0]   cross_r [5];
  logic signed [DW-1:0]   rx2_r, ry2_r, rx3_r, ry3_r;

  always_comb begin
    for (int i = 0; i < 12; i++) begin
      dif_nxt[i] = DW'(in_pt[DIF_P[i]]) - DW'(in_pt[DIF_Q[i]]);
    end
    for (int k = 0; k < 10; k++) begin
      prod_nxt[k] = XW'(dif_r[PROD_A[k]]) * XW'(dif_r[PROD_B[k]]);
    end
    for (int j = 0; j < 5; j++) begin
      cross_nxt[j] = prod_r[2*j] - prod_r[2*j+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 8; i++) begin
        pt1_r[i] <= in_pt[i];
        pt2_r[i] <= pt1_r[i];
        pt3_r[i] <= pt2_r[i];
      end
      for (int i = 0; i < 12; i++) begin
        dif_r[i] <= dif_nxt[i];
      end
      for (int k = 0; k < 10; k++) begin
        prod_r[k] <= prod_nxt[k];
      end
      for (int j = 0; j < 5; j++) begin
        cross_r[j] <= cross_nxt[j];
      end
      rx2_r <= dif_r[0];
      ry2_r <= dif_r[1];
      rx3_r <= rx2_r;
      ry3_r <= ry2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_pt    = pt3_r;
  assign out_cross = cross_r;
  assign out_rx    = rx3_r;
  assign out_ry    = ry3_r;

endmodule

### rtl/core/segi_classify.sv
// Classification: tolerance sign tests, box tests, collinear ordering and
// the numerators for the crossing point. Two register stages. Uses segi_pkg.
module segi_classify #(
  parameter int COORD_BITS = segi_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic signed [COORD_BITS-1:0]          in_pt [8],
  input  logic signed [2*COORD_BITS+1:0]        in_cross [5],
  input  logic signed [COORD_BITS:0]            in_rx,
  input  logic signed [COORD_BITS:0]            in_ry,
  input  logic [segi_pkg::TOL_BITS-1:0]         tol,
  output logic                                  out_valid,
  output segi_pkg::kind_t                       out_kind,
  output logic                                  out_hit,
  output logic                                  out_den_zero,
  output logic [1:0]                            out_neg,
  output logic signed [COORD_BITS-1:0]          out_pts [4],
  output logic [3*COORD_BITS+2:0]               out_num [2],
  output logic [2*COORD_BITS+1:0]               out_den
);

  localparam int TB  = segi_pkg::TOL_BITS;
  localparam int DW  = COORD_BITS + 1;
  localparam int XW  = 2 * COORD_BITS + 2;
  localparam int NPW = XW + DW;
  localparam int CMW = (XW > TB ? XW : TB) + 2;
  localparam int EW  = (COORD_BITS > TB ? COORD_BITS : TB) + 3;

  typedef logic signed [COORD_BITS-1:0] crd_t;

  function automatic logic pt_before(input crd_t px, input crd_t py,
                                     input crd_t qx, input crd_t qy);
    logic res;
    if (px != qx) begin
      res = px < qx;
    end else begin
      res = py < qy;
    end
    return res;
  endfunction

  function automatic logic in_box(input crd_t ex, input crd_t ey, input crd_t fx,
                                  input crd_t fy, input crd_t px, input crd_t py,
                                  input logic [TB-1:0] t);
    logic signed [EW-1:0] lx, hx, ly, hy, pxe, pye, te;
    lx  = (ex < fx) ? EW'(ex) : EW'(fx);
    hx  = (ex < fx) ? EW'(fx) : EW'(ex);
    ly  = (ey < fy) ? EW'(ey) : EW'(fy);
    hy  = (ey < fy) ? EW'(fy) : EW'(ey);
    pxe = EW'(px);
    pye = EW'(py);
    te  = EW'({1'b0, t});
    return (pxe >= lx - te) && (pxe <= hx + te) && (pye >= ly - te) && (pye <= hy + te);
  endfunction

  // stage 4
  logic              v4_r;
  logic [3:0]        pos_r, neg_r, box_r;
  logic [3:0]        pos_nxt, neg_nxt, box_nxt;
  crd_t              pt4_r [8];
  crd_t              srt_r [8];
  crd_t              srt_nxt [8];
  logic [XW-1:0]     d3m_r, denm_r;
  logic [DW-1:0]     rxm_r, rym_r;
  logic [1:0]        neg4_r;
  logic              dz4_r;
  logic [TB-1:0]     tol4_r;
  logic signed [CMW-1:0] tol_c, cr_c;

  always_comb begin
    tol_c = CMW'({1'b0, tol});
    for (int i = 0; i < 4; i++) begin
      cr_c       = CMW'(in_cross[i]);
      pos_nxt[i] = cr_c > tol_c;
      neg_nxt[i] = cr_c < -tol_c;
    end
    box_nxt[0] = in_box(in_pt[0], in_pt[1], in_pt[2], in_pt[3], in_pt[4], in_pt[5], tol);
    box_nxt[1] = in_box(in_pt[0], in_pt[1], in_pt[2], in_pt[3], in_pt[6], in_pt[7], tol);
    box_nxt[2] = in_box(in_pt[4], in_pt[5], in_pt[6], in_pt[7], in_pt[0], in_pt[1], tol);
    box_nxt[3] = in_box(in_pt[4], in_pt[5], in_pt[6], in_pt[7], in_pt[2], in_pt[3], tol);
    // order each segment's endpoints by x, then y
    for (int s = 0; s < 2; s++) begin
      if (pt_before(in_pt[4*s+2], in_pt[4*s+3], in_pt[4*s], in_pt[4*s+1])) begin
        srt_nxt[4*s]   = in_pt[4*s+2];
        srt_nxt[4*s+1] = in_pt[4*s+3];
        srt_nxt[4*s+2] = in_pt[4*s];
        srt_nxt[4*s+3] = in_pt[4*s+1];
      end else begin
        for (int i = 0; i < 4; i++) begin
          srt_nxt[4*s+i] = in_pt[4*s+i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_r  <= pos_nxt;
      neg_r  <= neg_nxt;
      box_r  <= box_nxt;
      for (int i = 0; i < 8; i++) begin
        pt4_r[i] <= in_pt[i];
        srt_r[i] <= srt_nxt[i];
      end
      d3m_r  <= in_cross[2][XW-1] ? XW'(-in_cross[2]) : XW'(in_cross[2]);
      denm_r <= in_cross[4][XW-1] ? XW'(-in_cross[4]) : XW'(in_cross[4]);
      rxm_r  <= in_rx[DW-1] ? DW'(-in_rx) : DW'(in_rx);
      rym_r  <= in_ry[DW-1] ? DW'(-in_ry) : DW'(in_ry);
      neg4_r[0] <= in_cross[2][XW-1] ^ in_rx[DW-1] ^ in_cross[4][XW-1];
      neg4_r[1] <= in_cross[2][XW-1] ^ in_ry[DW-1] ^ in_cross[4][XW-1];
      dz4_r  <= in_cross[4] == '0;
      tol4_r <= tol;
    end
  end

  // stage 5
  logic              v5_r;
  segi_pkg::kind_t   kind_nxt, kind_r;
  logic              hit_nxt, hit_r;
  logic              dz5_r;
  logic [1:0]        neg5_r;
  crd_t              pts_nxt [4];
  crd_t              pts_r [4];
  logic [NPW-1:0]    num_r [2];
  logic [XW-1:0]     den5_r;
  logic [3:0]        zero4;
  crd_t              lo_x, lo_y, hi_x, hi_y;
  logic signed [EW-1:0] ndx, ndy, nte;
  logic              lo_near;

  always_comb begin
    zero4 = ~pos_r & ~neg_r;
    if (pt_before(srt_r[0], srt_r[1], srt_r[4], srt_r[5])) begin
      lo_x = srt_r[4];
      lo_y = srt_r[5];
    end else begin
      lo_x = srt_r[0];
      lo_y = srt_r[1];
    end
    if (pt_before(srt_r[2], srt_r[3], srt_r[6], srt_r[7])) begin
      hi_x = srt_r[2];
      hi_y = srt_r[3];
    end else begin
      hi_x = srt_r[6];
      hi_y = srt_r[7];
    end
    ndx     = EW'(lo_x) - EW'(hi_x);
    ndy     = EW'(lo_y) - EW'(hi_y);
    nte     = EW'({1'b0, tol4_r});
    lo_near = (ndx <= nte) && (ndx >= -nte) && (ndy <= nte) && (ndy >= -nte);

    kind_nxt = segi_pkg::KIND_NONE;
    hit_nxt  = 1'b0;
    for (int i = 0; i < 4; i++) begin
      pts_nxt[i] = '0;
    end
    if (zero4 == 4'hf) begin
      if (lo_near) begin
        kind_nxt   = segi_pkg::KIND_POINT;
        pts_nxt[0] = lo_x;
        pts_nxt[1] = lo_y;
      end else if (pt_before(lo_x, lo_y, hi_x, hi_y)) begin
        kind_nxt   = segi_pkg::KIND_SEGMENT;
        pts_nxt[0] = lo_x;
        pts_nxt[1] = lo_y;
        pts_nxt[2] = hi_x;
        pts_nxt[3] = hi_y;
      end
    end else if (zero4[0] && box_r[0]) begin
      kind_nxt   = segi_pkg::KIND_POINT;
      pts_nxt[0] = pt4_r[4];
      pts_nxt[1] = pt4_r[5];
    end else if (zero4[1] && box_r[1]) begin
      kind_nxt   = segi_pkg::KIND_POINT;
      pts_nxt[0] = pt4_r[6];
      pts_nxt[1] = pt4_r[7];
    end else if (zero4[2] && box_r[2]) begin
      kind_nxt   = segi_pkg::KIND_POINT;
      pts_nxt[0] = pt4_r[0];
      pts_nxt[1] = pt4_r[1];
    end else if (zero4[3] && box_r[3]) begin
      kind_nxt   = segi_pkg::KIND_POINT;
      pts_nxt[0] = pt4_r[2];
      pts_nxt[1] = pt4_r[3];
    end else if (((pos_r[0] && neg_r[1]) || (neg_r[0] && pos_r[1])) &&
                 ((pos_r[2] && neg_r[3]) || (neg_r[2] && pos_r[3]))) begin
      // proper crossing: base point a, offset comes from the divider
      kind_nxt   = segi_pkg::KIND_POINT;
      hit_nxt    = 1'b1;
      pts_nxt[0] = pt4_r[0];
      pts_nxt[1] = pt4_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind_r <= kind_nxt;
      hit_r  <= hit_nxt;
      dz5_r  <= dz4_r;
      neg5_r <= neg4_r;
      for (int i = 0; i < 4; i++) begin
        pts_r[i] <= pts_nxt[i];
      end
      num_r[0] <= NPW'(d3m_r) * NPW'(rxm_r);
      num_r[1] <= NPW'(d3m_r) * NPW'(rym_r);
      den5_r   <= denm_r;
    end
  end

  assign out_valid    = v5_r;
  assign out_kind     = kind_r;
  assign out_hit      = hit_r;
  assign out_den_zero = dz5_r;
  assign out_neg      = neg5_r;
  assign out_pts      = pts_r;
  assign out_num      = num_r;
  assign out_den      = den5_r;

endmodule

### rtl/core/segi_div.sv
// Pipelined restoring divider, two lanes sharing one divisor, one quotient
// bit per stage, with a side tag carried alongside. Uses segi_pkg defaults.
module segi_div #(
  parameter int NPW  = 3 * segi_pkg::COORD_BITS_DEF + 3,
  parameter int XW   = 2 * segi_pkg::COORD_BITS_DEF + 2,
  parameter int FRAC = segi_pkg::FRAC_BITS_DEF,
  parameter int QB   = segi_pkg::COORD_BITS_DEF + 1 + segi_pkg::FRAC_BITS_DEF,
  parameter int TW   = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [NPW-1:0]  in_num [2],
  input  logic [XW-1:0]   in_den,
  input  logic [TW-1:0]   in_tag,
  output logic            out_valid,
  output logic [QB-1:0]   out_quo [2],
  output logic [TW-1:0]   out_tag
);

  localparam int NW = NPW + FRAC;
  localparam int RW = XW + 1;

  logic [QB-1:0]  vld_r;
  logic [RW-1:0]  rem_r [QB][2];
  logic [QB-1:0]  low_r [QB][2];
  logic [QB-1:0]  quo_r [QB][2];
  logic [XW-1:0]  dv_r  [QB];
  logic [TW-1:0]  tg_r  [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [RW-1:0]  rem_in [2];
    logic [QB-1:0]  low_in [2];
    logic [QB-1:0]  quo_in [2];
    logic [XW-1:0]  dv_in;
    logic [TW-1:0]  tg_in;
    logic           v_in;
    logic [RW-1:0]  trial [2];
    logic [1:0]     ge;
    logic [NW+RW-1:0] ext [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        ext[l] = (NW+RW)'(in_num[l]) << FRAC;
      end
      if (k == 0) begin
        // quotient fits in QB bits, so the part above goes straight to the remainder
        for (int l = 0; l < 2; l++) begin
          rem_in[l] = ext[l][QB +: RW];
          low_in[l] = ext[l][QB-1:0];
          quo_in[l] = '0;
        end
        dv_in = in_den;
        tg_in = in_tag;
        v_in  = in_valid;
      end else begin
        for (int l = 0; l < 2; l++) begin
          rem_in[l] = rem_r[k-1][l];
          low_in[l] = low_r[k-1][l];
          quo_in[l] = quo_r[k-1][l];
        end
        dv_in = dv_r[k-1];
        tg_in = tg_r[k-1];
        v_in  = vld_r[k-1];
      end
      for (int l = 0; l < 2; l++) begin
        trial[l] = {rem_in[l][RW-2:0], low_in[l][QB-1]};
        ge[l]    = trial[l] >= {1'b0, dv_in};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 2; l++) begin
          rem_r[k][l] <= ge[l] ? trial[l] - {1'b0, dv_in} : trial[l];
          low_r[k][l] <= low_in[l] << 1;
          quo_r[k][l] <= {quo_in[l][QB-2:0], ge[l]};
        end
        dv_r[k] <= dv_in;
        tg_r[k] <= tg_in;
      end
    end
  end

  assign out_valid  = vld_r[QB-1];
  assign out_quo[0] = quo_r[QB-1][0];
  assign out_quo[1] = quo_r[QB-1][1];
  assign out_tag    = tg_r[QB-1];

endmodule

### rtl/core/segment_intersection_unit.sv
// Top level of the segment intersection unit: input unpacking, tolerance
// register, output stage with fixed-point conversion and saturation.
// Instantiates segi_orient, segi_classify, segi_div; uses segi_pkg.
//
// Usage: each input item carries two segments (a to b, c to d) as signed
// integer endpoints; each item yields exactly one result item: kind on
// out_tuser (none, point, overlap segment) and up to two Q16.16 points on
// out_tdata. The tolerance register is written through cfg_wr_en and
// cfg_wr_data while no items are in flight.
// The pipe has three orientation stages, two classification stages, one
// divider stage per quotient bit (COORD_BITS + FRAC_BITS + 1) and the
// output register. Throughput is one item per cycle while not stalled;
// the divider stages set the depth.
// All stages advance together: when out_tready is low and the output
// register holds an item, in_tready falls and the whole pipe holds, so
// nothing is lost or repeated. Empty stages never block.
// Reset clears all valid bits and the tolerance to zero; in_tready stays
// low while reset is held.
module segment_intersection_unit #(
  parameter int COORD_BITS = segi_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = segi_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // first_ax, first_ay, first_bx, first_by, second_cx, second_cy, second_dx, second_dy
  input  logic [8*COORD_BITS-1:0]          in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // first_px, first_py, second_px, second_py
  output logic [4*segi_pkg::OUT_BITS-1:0]  out_tdata,
  // kind
  output logic [1:0]                       out_tuser,
  input  logic                             cfg_wr_en,
  input  logic [segi_pkg::TOL_BITS-1:0]    cfg_wr_data
);

  localparam int OB  = segi_pkg::OUT_BITS;
  localparam int DW  = COORD_BITS + 1;
  localparam int XW  = 2 * COORD_BITS + 2;
  localparam int NPW = XW + DW;
  localparam int QB  = COORD_BITS + 1 + FRAC_BITS;
  localparam int TW  = 6 + 4 * COORD_BITS;
  localparam int SW  = (QB + 2 > OB + 2) ? QB + 2 : OB + 2;
  localparam logic signed [SW-1:0] SAT_HI = SW'(64'sd2147483647);
  localparam logic signed [SW-1:0] SAT_LO = SW'(-64'sd2147483648);

  typedef logic signed [COORD_BITS-1:0] crd_t;

  function automatic logic [OB-1:0] sat_out(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = v;
    if (v > SAT_HI) begin
      r = SAT_HI;
    end else if (v < SAT_LO) begin
      r = SAT_LO;
    end
    return r[OB-1:0];
  endfunction

  function automatic logic signed [SW-1:0] to_fix(input crd_t v);
    return SW'(v) <<< FRAC_BITS;
  endfunction

  logic             en;
  logic [segi_pkg::TOL_BITS-1:0] tol_r;
  crd_t             in_pt [8];

  logic             o_valid;
  crd_t             o_pt [8];
  logic signed [XW-1:0] o_cross [5];
  logic signed [DW-1:0] o_rx, o_ry;

  logic             c_valid;
  segi_pkg::kind_t  c_kind;
  logic             c_hit, c_dz;
  logic [1:0]       c_neg;
  crd_t             c_pts [4];
  logic [NPW-1:0]   c_num [2];
  logic [XW-1:0]    c_den;
  logic [TW-1:0]    c_tag;

  logic             d_valid;
  logic [QB-1:0]    d_quo [2];
  logic [TW-1:0]    d_tag;

  segi_pkg::kind_t  t_kind;
  logic             t_hit, t_dz;
  logic [1:0]       t_neg;
  crd_t             t_pts [4];

  logic             out_valid_r;
  logic [1:0]       out_kind_r;
  logic [OB-1:0]    fix_r [4];
  logic [OB-1:0]    fix_nxt [4];
  logic signed [SW-1:0] off [2];

  // whole pipe holds only when a finished item waits at the output
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en && rst_n;

  for (genvar i = 0; i < 8; i++) begin : g_unpack
    assign in_pt[i] = $signed(in_tdata[i*COORD_BITS +: COORD_BITS]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  segi_orient #(.COORD_BITS(COORD_BITS)) u_orient (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .in_pt    (in_pt),
    .out_valid(o_valid),
    .out_pt   (o_pt),
    .out_cross(o_cross),
    .out_rx   (o_rx),
    .out_ry   (o_ry)
  );

  segi_classify #(.COORD_BITS(COORD_BITS)) u_classify (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (o_valid),
    .in_pt       (o_pt),
    .in_cross    (o_cross),
    .in_rx       (o_rx),
    .in_ry       (o_ry),
    .tol         (tol_r),
    .out_valid   (c_valid),
    .out_kind    (c_kind),
    .out_hit     (c_hit),
    .out_den_zero(c_dz),
    .out_neg     (c_neg),
    .out_pts     (c_pts),
    .out_num     (c_num),
    .out_den     (c_den)
  );

  assign c_tag = {c_pts[3], c_pts[2], c_pts[1], c_pts[0], c_neg, c_dz, c_hit, c_kind};

  segi_div #(
    .NPW (NPW),
    .XW  (XW),
    .FRAC(FRAC_BITS),
    .QB  (QB),
    .TW  (TW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (c_valid),
    .in_num   (c_num),
    .in_den   (c_den),
    .in_tag   (c_tag),
    .out_valid(d_valid),
    .out_quo  (d_quo),
    .out_tag  (d_tag)
  );

  assign t_kind = segi_pkg::kind_t'(d_tag[1:0]);
  assign t_hit  = d_tag[2];
  assign t_dz   = d_tag[3];
  assign t_neg  = d_tag[5:4];
  for (genvar i = 0; i < 4; i++) begin : g_tag
    assign t_pts[i] = $signed(d_tag[6 + i*COORD_BITS +: COORD_BITS]);
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      off[l] = SW'({1'b0, d_quo[l]});
      if (t_neg[l]) begin
        off[l] = -off[l];
      end
      if (t_dz || !t_hit) begin
        off[l] = '0;
      end
    end
    for (int i = 0; i < 4; i++) begin
      fix_nxt[i] = '0;
    end
    case (t_kind)
      segi_pkg::KIND_POINT: begin
        fix_nxt[0] = sat_out(to_fix(t_pts[0]) + off[0]);
        fix_nxt[1] = sat_out(to_fix(t_pts[1]) + off[1]);
      end
      segi_pkg::KIND_SEGMENT: begin
        for (int i = 0; i < 4; i++) begin
          fix_nxt[i] = sat_out(to_fix(t_pts[i]));
        end
      end
      default: begin
        for (int i = 0; i < 4; i++) begin
          fix_nxt[i] = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_kind_r <= t_kind;
      for (int i = 0; i < 4; i++) begin
        fix_r[i] <= fix_nxt[i];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {fix_r[3], fix_r[2], fix_r[1], fix_r[0]};

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == segi_pkg::KIND_NONE |-> out_tdata == '0)
    else $error("no-intersection result carries nonzero coordinates");

  a_point_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == segi_pkg::KIND_POINT |-> out_tdata[4*OB-1:2*OB] == '0)
    else $error("point result carries a nonzero end point");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == segi_pkg::KIND_NONE || out_tuser == segi_pkg::KIND_POINT ||
                    out_tuser == segi_pkg::KIND_SEGMENT))
    else $error("illegal kind code on output");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("pipe held without a waiting output item");

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for segment_intersection_unit: random and directed
// segment pairs, tolerance changes between phases, random stalls on both sides.
// Depends on segi_pkg and the unit's RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = 16;
  localparam int FB = 16;
  localparam int LATENCY = CB + FB + 7;

  typedef struct {
    segi_pkg::kind_t kind;
    logic signed [31:0] p0x, p0y, p1x, p1y;
  } isect_t;

  typedef struct {
    longint x, y;
  } vtx_t;

  class isect_board;
    logic [segi_pkg::TOL_BITS-1:0] tol = '0;
    isect_t pending[$];
    int n_fail, n_seen;
    int n_kind[3];

    function longint cross3(vtx_t a, vtx_t b, vtx_t c);
      return (b.x - a.x) * (c.y - a.y) - (b.y - a.y) * (c.x - a.x);
    endfunction

    function int sgn(longint v);
      longint e;
      e = longint'(tol);
      if (v > e) return 1;
      if (v < -e) return -1;
      return 0;
    endfunction

    function bit precedes(vtx_t p, vtx_t q);
      if (p.x != q.x) return p.x < q.x;
      return p.y < q.y;
    endfunction

    function bit close_to(vtx_t p, vtx_t q);
      longint e, dx, dy;
      e = longint'(tol);
      dx = p.x - q.x;
      dy = p.y - q.y;
      return dx <= e && dx >= -e && dy <= e && dy >= -e;
    endfunction

    function bit in_bbox(vtx_t a, vtx_t b, vtx_t p);
      longint e, lx, hx, ly, hy;
      e = longint'(tol);
      lx = a.x < b.x ? a.x : b.x;
      hx = a.x < b.x ? b.x : a.x;
      ly = a.y < b.y ? a.y : b.y;
      hy = a.y < b.y ? b.y : a.y;
      return p.x >= lx - e && p.x <= hx + e && p.y >= ly - e && p.y <= hy + e;
    endfunction

    function logic signed [31:0] clamp32(logic signed [127:0] v);
      if (v > 128'sd2147483647) return 32'h7fffffff;
      if (v < -128'sd2147483648) return 32'h80000000;
      return v[31:0];
    endfunction

    // trunc(n * m * 2^FB / den), toward zero
    function logic signed [127:0] offset_q(longint n, longint m, longint den);
      logic signed [127:0] num, q;
      if (den == 0) return 0;
      num = (128'(signed'(n)) * 128'(signed'(m))) <<< FB;
      q = num / 128'(signed'(den));
      return q;
    endfunction

    function void note_item(logic [8*CB-1:0] d);
      vtx_t a, b, c, e, A, B, C, D, t, lo, hi;
      longint d1, d2, d3, d4, rx, ry, den;
      int s1, s2, s3, s4;
      isect_t r;
      a.x = longint'($signed(d[0*CB +: CB])); a.y = longint'($signed(d[1*CB +: CB]));
      b.x = longint'($signed(d[2*CB +: CB])); b.y = longint'($signed(d[3*CB +: CB]));
      c.x = longint'($signed(d[4*CB +: CB])); c.y = longint'($signed(d[5*CB +: CB]));
      e.x = longint'($signed(d[6*CB +: CB])); e.y = longint'($signed(d[7*CB +: CB]));
      r = '{segi_pkg::KIND_NONE, 0, 0, 0, 0};
      d1 = cross3(a, b, c); d2 = cross3(a, b, e);
      d3 = cross3(c, e, a); d4 = cross3(c, e, b);
      s1 = sgn(d1); s2 = sgn(d2); s3 = sgn(d3); s4 = sgn(d4);
      if (s1 == 0 && s2 == 0 && s3 == 0 && s4 == 0) begin
        A = a; B = b; C = c; D = e;
        if (precedes(B, A)) begin t = A; A = B; B = t; end
        if (precedes(D, C)) begin t = C; C = D; D = t; end
        lo = precedes(A, C) ? C : A;
        hi = precedes(B, D) ? B : D;
        if (close_to(lo, hi)) begin
          r.kind = segi_pkg::KIND_POINT;
          r.p0x = clamp32(lo.x <<< FB); r.p0y = clamp32(lo.y <<< FB);
        end else if (precedes(lo, hi)) begin
          r.kind = segi_pkg::KIND_SEGMENT;
          r.p0x = clamp32(lo.x <<< FB); r.p0y = clamp32(lo.y <<< FB);
          r.p1x = clamp32(hi.x <<< FB); r.p1y = clamp32(hi.y <<< FB);
        end
      end else if (s1 == 0 && in_bbox(a, b, c)) begin
        r.kind = segi_pkg::KIND_POINT;
        r.p0x = clamp32(c.x <<< FB); r.p0y = clamp32(c.y <<< FB);
      end else if (s2 == 0 && in_bbox(a, b, e)) begin
        r.kind = segi_pkg::KIND_POINT;
        r.p0x = clamp32(e.x <<< FB); r.p0y = clamp32(e.y <<< FB);
      end else if (s3 == 0 && in_bbox(c, e, a)) begin
        r.kind = segi_pkg::KIND_POINT;
        r.p0x = clamp32(a.x <<< FB); r.p0y = clamp32(a.y <<< FB);
      end else if (s4 == 0 && in_bbox(c, e, b)) begin
        r.kind = segi_pkg::KIND_POINT;
        r.p0x = clamp32(b.x <<< FB); r.p0y = clamp32(b.y <<< FB);
      end else if (s1 * s2 < 0 && s3 * s4 < 0) begin
        rx = b.x - a.x; ry = b.y - a.y;
        den = rx * (e.y - c.y) - ry * (e.x - c.x);
        r.kind = segi_pkg::KIND_POINT;
        r.p0x = clamp32((128'(signed'(a.x)) <<< FB) + offset_q(d3, rx, den));
        r.p0y = clamp32((128'(signed'(a.y)) <<< FB) + offset_q(d3, ry, den));
      end
      pending = {pending, r};
    endfunction

    function void check_result(logic [1:0] k, logic [4*segi_pkg::OUT_BITS-1:0] d);
      isect_t x;
      if (pending.size() == 0) begin
        $error("result with nothing pending: kind %0d", k);
        n_fail++;
        return;
      end
      x = pending.pop_front();
      n_seen++;
      if (k <= 2) n_kind[k]++;
      if (k !== x.kind) begin
        $error("kind: expected %0d, got %0d", x.kind, k); n_fail++;
      end
      if (d[31:0] !== x.p0x) begin
        $error("first_px: expected %0d, got %0d", x.p0x, $signed(d[31:0])); n_fail++;
      end
      if (d[63:32] !== x.p0y) begin
        $error("first_py: expected %0d, got %0d", x.p0y, $signed(d[63:32])); n_fail++;
      end
      if (d[95:64] !== x.p1x) begin
        $error("second_px: expected %0d, got %0d", x.p1x, $signed(d[95:64])); n_fail++;
      end
      if (d[127:96] !== x.p1y) begin
        $error("second_py: expected %0d, got %0d", x.p1y, $signed(d[127:96])); n_fail++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [8*CB-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [4*segi_pkg::OUT_BITS-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_wr_en = 1'b0;
  logic [segi_pkg::TOL_BITS-1:0] cfg_wr_data = '0;

  isect_board board = new();
  bit stall_hard = 1'b0;
  int n_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  segment_intersection_unit #(.COORD_BITS(CB), .FRAC_BITS(FB)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random back-pressure, checks on every accepted item
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tuser, out_tdata);
  end

  initial begin
    int g;
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      @(posedge clk);
      if (!stall_hard && $urandom_range(0, 3) == 0) begin
        g = gap_len();
        if (g > 0) begin
          out_tready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  task automatic send_item(logic [8*CB-1:0] d);
    int g;
    g = stall_hard ? 0 : gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_item(d);
    n_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic set_tol(logic [segi_pkg::TOL_BITS-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.tol = v;
    @(posedge clk);
  endtask

  function logic [CB-1:0] rnd_coord(int span);
    if (span == 0) return CB'($urandom);
    return CB'($urandom_range(0, 2 * span) - span);
  endfunction

  function logic [8*CB-1:0] pack8(int v[8]);
    logic [8*CB-1:0] d;
    for (int i = 0; i < 8; i++) d[i*CB +: CB] = CB'(v[i]);
    return d;
  endfunction

  // collinear pair on a random line, or a touching or crossing pair
  function logic [8*CB-1:0] shaped_item(int span);
    int v[8];
    int ox, oy, ux, uy, t0, t1, t2, t3, m;
    m = $urandom_range(0, 3);
    ox = $signed(rnd_coord(span / 2)); oy = $signed(rnd_coord(span / 2));
    ux = $urandom_range(0, 8) - 4; uy = $urandom_range(0, 8) - 4;
    t0 = $urandom_range(0, 40) - 20; t1 = $urandom_range(0, 40) - 20;
    t2 = $urandom_range(0, 40) - 20; t3 = $urandom_range(0, 40) - 20;
    v = '{ox + t0 * ux, oy + t0 * uy, ox + t1 * ux, oy + t1 * uy,
          ox + t2 * ux, oy + t2 * uy, ox + t3 * ux, oy + t3 * uy};
    if (m == 1) begin
      // second segment starts on the first one's end, leaves off the line
      v[4] = v[2]; v[5] = v[3];
      v[6] = v[4] + $urandom_range(0, 60) - 30; v[7] = v[5] + $urandom_range(0, 60) - 30;
    end else if (m == 2) begin
      v[4] = v[0] + $urandom_range(0, 4) - 2 + uy * 10;
      v[5] = v[1] + $urandom_range(0, 4) - 2 - ux * 10;
      v[6] = v[2] - uy * 10; v[7] = v[3] + ux * 10;
    end
    for (int i = 0; i < 8; i++) if ($urandom_range(0, 30) == 0) v[i] ^= 1 << $urandom_range(0, 15);
    return pack8(v);
  endfunction

  function logic [8*CB-1:0] rnd_item(int span);
    logic [8*CB-1:0] d;
    for (int i = 0; i < 8; i++) d[i*CB +: CB] = rnd_coord(span);
    return d;
  endfunction

  initial begin
    int spans[4];
    logic [segi_pkg::TOL_BITS-1:0] tols[5];
    spans = '{0, 32767, 300, 20};
    tols = '{20'd1, 20'd1000, 20'hfffff, 20'd3, 20'd0};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, crossing, touching, collinear overlap, collinear point, disjoint
    send_item(pack8('{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768}));
    send_item(pack8('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}));
    send_item(pack8('{-32768, -32768, -32768, -32768, -32768, -32768, 32767, 32767}));
    send_item(pack8('{0, 0, 10, 0, 5, -5, 5, 5}));
    send_item(pack8('{0, 0, 3, 7, 0, 7, 3, 0}));
    send_item(pack8('{0, 0, 10, 0, 5, 0, 5, 9}));
    send_item(pack8('{0, 0, 10, 0, 10, 0, 10, 9}));
    send_item(pack8('{5, 5, 5, 9, 0, 0, 10, 10}));
    send_item(pack8('{0, 0, 10, 10, 5, 5, 20, 20}));
    send_item(pack8('{10, 10, 0, 0, 20, 20, 10, 10}));
    send_item(pack8('{0, 0, 0, 10, 0, 20, 0, 3}));
    send_item(pack8('{0, 0, 4, 4, 5, 5, 9, 9}));
    send_item(pack8('{0, 0, 10, 0, 0, 1, 10, 1}));
    send_item(pack8('{0, 0, 10, 0, 20, -5, 20, 5}));
    send_item(pack8('{3, 3, 3, 3, 3, 3, 3, 3}));
    send_item(pack8('{3, 3, 3, 3, 4, 4, 4, 4}));
    send_item(pack8('{-32768, 0, 32767, 1, 0, -32768, 1, 32767}));
    send_item(pack8('{-1, -1, 1, 1, 1, -1, -1, 1}));
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      set_tol(tols[ph]);
      for (int i = 0; i < 360; i++) begin
        if (i == 180) begin
          // hold off until the pipe is empty, then push a back-to-back burst
          drain();
          stall_hard = 1'b1;
        end
        if (i == 230) stall_hard = 1'b0;
        if ($urandom_range(0, 99) < 60) send_item(shaped_item(spans[$urandom_range(1, 3)]));
        else send_item(rnd_item(spans[$urandom_range(0, 3)]));
      end
      drain();
    end

    $display("Covered %0d items over 5 tolerance settings incl. 0 and max;", n_sent);
    $display("results: none %0d, point %0d, overlap %0d.",
             board.n_kind[0], board.n_kind[1], board.n_kind[2]);
    if (board.n_fail == 0 && board.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
